@@ design/dctt_pkg.sv @@
// ----------------------------------------------------------------------------
// Deferred condition trigger table: shared definitions
// Operation codes, condition codes, result kinds, tolerances, sequencer
// states and the record types passed between the modules.
// ----------------------------------------------------------------------------
package dctt_pkg;

   // Operation codes of an input word.
   typedef enum logic [1:0] {
      OP_ADD       = 2'd0,
      OP_SET_CLOCK = 2'd1,
      OP_SAMPLE    = 2'd2,
      OP_SCAN      = 2'd3
   } op_type;

   // Condition codes; code seven behaves as never.
   localparam logic [2:0] COND_GE    = 3'd0;
   localparam logic [2:0] COND_LE    = 3'd1;
   localparam logic [2:0] COND_W1    = 3'd2;
   localparam logic [2:0] COND_W10   = 3'd3;
   localparam logic [2:0] COND_W100  = 3'd4;
   localparam logic [2:0] COND_W1000 = 3'd5;
   localparam logic [2:0] COND_NEVER = 3'd6;

   // Result kinds.
   localparam logic [1:0] KIND_ADDED = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Tolerances in raw Q24.8 units, at the width of the difference.
   localparam logic signed [32:0] TOL_1    = 33'sd256;
   localparam logic signed [32:0] TOL_10   = 33'sd2560;
   localparam logic signed [32:0] TOL_100  = 33'sd25600;
   localparam logic signed [32:0] TOL_1000 = 33'sd256000;

   // Width of the channel field on the ports.
   localparam int CHAN_FIELD_W = 4;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_FIND   = 8'b00000010,
      ST_WRITE  = 8'b00000100,
      ST_REJECT = 8'b00001000,
      ST_ADDR   = 8'b00010000,
      ST_CHAN   = 8'b00100000,
      ST_EVAL   = 8'b01000000,
      ST_CLOSE  = 8'b10000000
   } state_type;

   // One stored task.
   typedef struct packed {
      logic [7:0]         task_id;
      logic [3:0]         channel;
      logic [2:0]         condition;
      logic signed [31:0] target;
      logic [32:0]        deadline;
   } slot_rec_type;

   // What the shared arithmetic unit reports.
   typedef struct packed {
      logic               cond_met;
      logic signed [31:0] sat_sum;
   } alu_res_type;

endpackage

@@ design/dctt_alu.sv @@
// ----------------------------------------------------------------------------
// Deferred condition trigger table: shared arithmetic unit
// One 33-bit adder serves both the saturated target sum of an add and the
// difference against the target in a scan, followed by the condition test.
// ----------------------------------------------------------------------------
module dctt_alu (
   input  logic                  sub,
   input  logic signed [31:0]    op_a,
   input  logic signed [31:0]    op_b,
   input  logic [2:0]            condition,
   output dctt_pkg::alu_res_type res
);
   import dctt_pkg::*;

   logic [32:0]        b_ext;
   logic [32:0]        b_opnd;
   logic signed [32:0] sum;

   // Add or subtract in 33 bits, so neither can overflow.
   assign b_ext  = {op_b[31], op_b};
   assign b_opnd = sub ? ~b_ext : b_ext;
   assign sum    = $signed({op_a[31], op_a} + b_opnd + {32'd0, sub});

   // Saturate the sum to the signed 32-bit range, and test the condition on
   // the difference current minus target.
   always_comb begin
      if (sum[32] != sum[31]) begin
         res.sat_sum = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         res.sat_sum = sum[31:0];
      end

      unique case (condition)
         COND_GE:    res.cond_met = !sum[32];
         COND_LE:    res.cond_met = sum[32] || (sum == 33'sd0);
         COND_W1:    res.cond_met = (sum > -TOL_1) && (sum < TOL_1);
         COND_W10:   res.cond_met = (sum > -TOL_10) && (sum < TOL_10);
         COND_W100:  res.cond_met = (sum > -TOL_100) && (sum < TOL_100);
         COND_W1000: res.cond_met = (sum > -TOL_1000) && (sum < TOL_1000);
         COND_NEVER: res.cond_met = 1'b0;
         default:    res.cond_met = 1'b0;
      endcase
   end

endmodule

@@ design/dctt_chan_mem.sv @@
// ----------------------------------------------------------------------------
// Deferred condition trigger table: channel value memory
// Holds the latest value of each monitored channel. Entries carry valid bits
// so that unwritten channels, and channels out of range, read as zero.
// ----------------------------------------------------------------------------
module dctt_chan_mem #(
   parameter int CHANNELS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [dctt_pkg::CHAN_FIELD_W-1:0]    wr_chan,
   input  logic signed [31:0]                   wr_data,
   input  logic [dctt_pkg::CHAN_FIELD_W-1:0]    rd_chan,
   output logic signed [31:0]                   rd_data
);
   import dctt_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic signed [31:0] mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] valid_in;
   logic [CH_W-1:0]     wr_idx;
   logic [CH_W-1:0]     rd_idx;
   logic                wr_ok;
   logic                rd_in_range;
   logic                rd_ok_ff;
   logic signed [31:0]  rd_data_ff;

   // Range checks against the channel count.
   assign wr_idx      = CH_W'(wr_chan);
   assign rd_idx      = CH_W'(rd_chan);
   assign wr_ok       = wr_en && ({5'd0, wr_chan} < 9'(CHANNELS));
   assign rd_in_range = {5'd0, rd_chan} < 9'(CHANNELS);

   // Valid bits: set on the first write to each channel.
   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rd_ok_ff <= rd_in_range && valid_ff[rd_idx];
      end
   end

   // Storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : 32'sd0;

endmodule

@@ design/deferred_condition_trigger_table.sv @@
// Set clock and sample give no word; one word is taken at a time.
// An add walks ST_FIND from slot zero up to the lowest free slot, then stores and
// responds in ST_WRITE, or rejects in ST_REJECT when every slot is busy.
// A scan skips free slots in ST_ADDR and takes each busy one through ST_CHAN and
// ST_EVAL, then closes in ST_CLOSE. The slots are walked through one compare unit.
// Result stalls hold the sequencer. Reset clears the busy bits, channel valid bits and clock.
// ----------------------------------------------------------------------------
// Deferred condition trigger table
// Slot table of deferred tasks, each watching a channel against a target
// and an optional deadline, walked by a small sequencer for add and scan.
// ----------------------------------------------------------------------------
module deferred_condition_trigger_table #(
   parameter int SLOTS    = 8,
   parameter int CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_task_id,
   input  logic [3:0]         req_channel,
   input  logic [2:0]         req_condition,
   input  logic signed [31:0] req_offset,
   input  logic [31:0]        req_timeout,
   input  logic [31:0]        req_time_now,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_slot,
   output logic [7:0]         rsp_fired_task,
   output logic               rsp_last
);
   import dctt_pkg::*;

   localparam int              SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   // Sequencer and table state.
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOTS-1:0]   busy_ff, busy_in;
   logic [31:0]        clock_ff, clock_in;

   // Captured add request.
   logic [7:0]         item_task_ff, item_task_in;
   logic [3:0]         item_channel_ff, item_channel_in;
   logic [2:0]         item_cond_ff, item_cond_in;
   logic signed [31:0] item_offset_ff, item_offset_in;
   logic [31:0]        item_timeout_ff, item_timeout_in;

   // Fired slot held back until it is known whether it is the last one.
   logic               pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [7:0]         pend_task_ff, pend_task_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [2:0]         rsp_slot_ff, rsp_slot_in;
   logic [7:0]         rsp_task_ff, rsp_task_in;
   logic               rsp_last_ff, rsp_last_in;

   // Slot memory.
   slot_rec_type       slot_mem [SLOTS];
   slot_rec_type       slot_rd_ff;
   slot_rec_type       slot_wr;
   logic               slot_we;

   // Shared datapath.
   logic               out_free;
   logic               is_last;
   logic               scan_rd;
   logic               chan_we;
   logic [3:0]         chan_rd_addr;
   logic signed [31:0] chan_value;
   alu_res_type        alu_res;
   logic               dl_hit;
   logic               fire;
   logic [32:0]        add_deadline;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = (idx_ff == LAST_IDX);
   assign scan_rd   = (state_ff == ST_CHAN) || (state_ff == ST_EVAL);

   // Channel values, read for the add target or the slot under scan.
   assign chan_we      = req_valid && req_ready && (op_type'(req_op) == OP_SAMPLE);
   assign chan_rd_addr = scan_rd ? slot_rd_ff.channel : item_channel_ff;

   dctt_chan_mem #(
      .CHANNELS (CHANNELS)
   ) u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (chan_we),
      .wr_chan (req_channel),
      .wr_data (req_sample),
      .rd_chan (chan_rd_addr),
      .rd_data (chan_value)
   );

   // One adder: target sum during an add, difference during a scan.
   dctt_alu u_alu (
      .sub       (scan_rd),
      .op_a      (chan_value),
      .op_b      (scan_rd ? slot_rd_ff.target : item_offset_ff),
      .condition (slot_rd_ff.condition),
      .res       (alu_res)
   );

   // Deadline test and the deadline of a new task.
   assign dl_hit       = (slot_rd_ff.deadline != 33'd0) &&
                         ({1'b0, clock_ff} >= slot_rd_ff.deadline);
   assign fire         = alu_res.cond_met || dl_hit;
   assign add_deadline = (item_timeout_ff == 32'd0) ? 33'd0 :
                         ({1'b0, clock_ff} + {1'b0, item_timeout_ff});

   always_comb begin
      slot_wr.task_id   = item_task_ff;
      slot_wr.channel   = item_channel_ff;
      slot_wr.condition = item_cond_ff;
      slot_wr.target    = alu_res.sat_sum;
      slot_wr.deadline  = add_deadline;
   end

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      busy_in         = busy_ff;
      clock_in        = clock_ff;
      item_task_in    = item_task_ff;
      item_channel_in = item_channel_ff;
      item_cond_in    = item_cond_ff;
      item_offset_in  = item_offset_ff;
      item_timeout_in = item_timeout_ff;
      pend_valid_in   = pend_valid_ff;
      pend_slot_in    = pend_slot_ff;
      pend_task_in    = pend_task_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_task_in     = rsp_task_ff;
      rsp_last_in     = rsp_last_ff;
      slot_we         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (op_type'(req_op))
                  OP_ADD: begin
                     item_task_in    = req_task_id;
                     item_channel_in = req_channel;
                     item_cond_in    = req_condition;
                     item_offset_in  = req_offset;
                     item_timeout_in = req_timeout;
                     idx_in          = '0;
                     state_in        = ST_FIND;
                  end
                  OP_SET_CLOCK: begin
                     clock_in = req_time_now;
                  end
                  OP_SAMPLE: begin
                     // Written into the channel memory directly.
                  end
                  OP_SCAN: begin
                     idx_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_ADDR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIND: begin
            // Walk up to the lowest free slot.
            if (!busy_ff[idx_ff]) begin
               state_in = ST_WRITE;
            end else if (is_last) begin
               state_in = ST_REJECT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               slot_we          = 1'b1;
               busy_in[idx_ff]  = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = KIND_ADDED;
               rsp_slot_in      = 3'(idx_ff);
               rsp_task_in      = 8'd0;
               rsp_last_in      = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FULL;
               rsp_slot_in  = 3'd0;
               rsp_task_in  = 8'd0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ADDR: begin
            // Free slots are skipped; the end of the walk closes the scan.
            if (busy_ff[idx_ff]) begin
               state_in = ST_CHAN;
            end else if (is_last) begin
               state_in = ST_CLOSE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CHAN: begin
            // Channel value of this slot arrives in the next cycle.
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!fire || !pend_valid_ff || out_free) begin
               if (fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_FIRED;
                     rsp_slot_in  = 3'(pend_slot_ff);
                     rsp_task_in  = pend_task_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_slot_in    = idx_ff;
                  pend_task_in    = slot_rd_ff.task_id;
                  busy_in[idx_ff] = 1'b0;
               end
               // After the last slot the scan is closed.
               if (is_last) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_ADDR;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         ST_CLOSE: begin
            // The held fired slot, if any, goes out as the last word.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_FIRED;
               rsp_slot_in   = 3'(pend_slot_ff);
               rsp_task_in   = pend_task_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         clock_ff      <= 32'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         clock_ff      <= clock_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      item_task_ff    <= item_task_in;
      item_channel_ff <= item_channel_in;
      item_cond_ff    <= item_cond_in;
      item_offset_ff  <= item_offset_in;
      item_timeout_ff <= item_timeout_in;
      pend_slot_ff    <= pend_slot_in;
      pend_task_ff    <= pend_task_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_task_ff     <= rsp_task_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // Slot memory with a registered read at the walk index.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[idx_ff] <= slot_wr;
      end
      slot_rd_ff <= slot_mem[idx_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_fired_task = rsp_task_ff;
   assign rsp_last       = rsp_last_ff;

   // Add results are single words with no task identifier.
   a_add_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_FIRED)) |-> (rsp_last && (rsp_fired_task == 8'd0)))
      else $error("add result without last or with a task identifier");

   // The spare result kind is never produced.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != KIND_SPARE))
      else $error("illegal result kind");

   // A scan or an add keeps the block busy in the following cycle.
   a_busy_after_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && ((req_op == OP_SCAN) || (req_op == OP_ADD)))
      |=> !req_ready)
      else $error("ready while walking the slots");

   // A stalled result word is not overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_slot) &&
                                     $stable(rsp_fired_task) && $stable(rsp_last)))
      else $error("result word changed while stalled");

endmodule
